// ===== hdl/npcs_pkg.sv =====
// Shared constants, types and helper functions for the nearest palette colour search.
package npcs_pkg;

    localparam int PAL_ENTRIES = 256;
    localparam int ADDR_W      = (PAL_ENTRIES > 1) ? $clog2(PAL_ENTRIES) : 1;
    localparam int CNT_W       = $clog2(PAL_ENTRIES + 1);

    localparam int IDX_W   = 8;
    localparam int COMP_IN_W = 10;
    localparam int COMP_W  = 8;
    localparam int SQ_W    = 2 * COMP_W;
    localparam int DIST_W  = SQ_W + 2;
    localparam int VALUE_W = 24;
    localparam int ENTRY_W = 3 * COMP_W;

    localparam logic [DIST_W-1:0] NEAR_LIMIT = DIST_W'(8);
    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [COMP_IN_W-1:0] COMP_MAX = COMP_IN_W'(255);

    typedef enum logic [1:0] {
        MODE_INDEXED = 2'd0,
        MODE_RGB565  = 2'd1,
        MODE_RGB888  = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_FIND  = 1'b1
    } req_t;

    typedef struct packed {
        logic              capture;
        logic              wr_en;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              out_load;
    } npcs_cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  busy;
        logic  stop;
    } npcs_stat_t;

    function automatic logic [COMP_W-1:0] sat8(input logic [COMP_IN_W-1:0] v);
        logic [COMP_W-1:0] res;
        res = (v > COMP_MAX) ? {COMP_W{1'b1}} : v[COMP_W-1:0];
        return res;
    endfunction

    function automatic logic [SQ_W-1:0] sq_diff(input logic [COMP_W-1:0] a,
                                                 input logic [COMP_W-1:0] b);
        logic [COMP_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return SQ_W'(d) * SQ_W'(d);
    endfunction

endpackage

// ===== hdl/npcs_if.sv =====
// Request and response channel interfaces.
interface npcs_req_if;
    import npcs_pkg::*;
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [IDX_W-1:0]     entry_index;
    logic [COMP_IN_W-1:0] red;
    logic [COMP_IN_W-1:0] green;
    logic [COMP_IN_W-1:0] blue;

    modport source (output valid, req_type, entry_index, red, green, blue, input ready);
    modport sink (input valid, req_type, entry_index, red, green, blue, output ready);
endinterface

interface npcs_rsp_if;
    import npcs_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] colour_value;
    logic               colour_found;

    modport source (output valid, colour_value, colour_found, input ready);
    modport sink (input valid, colour_value, colour_found, output ready);
endinterface

// ===== hdl/npcs_ctrl.sv =====
// Controller: request acceptance, palette scan sequencing and result handoff.
module npcs_ctrl
    import npcs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_req_type,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  npcs_stat_t stat,
    output npcs_cmd_t  cmd
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_vld_reg, out_vld_next;
    logic             in_xfer;
    logic             issue_done;

    assign in_ready   = (state_reg == ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign out_valid  = out_vld_reg;
    assign issue_done = (cnt_reg == CNT_W'(PAL_ENTRIES)) || stat.stop;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd.capture  = 1'b0;
        cmd.wr_en    = 1'b0;
        cmd.rd_en    = 1'b0;
        cmd.rd_addr  = cnt_reg[ADDR_W-1:0];
        cmd.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (req_t'(in_req_type) == REQ_WRITE)
                    begin
                        cmd.wr_en = 1'b1;
                    end
                    else
                    begin
                        cmd.capture = 1'b1;
                        cnt_next    = '0;
                        state_next  = (stat.mode == MODE_INDEXED) ? ST_SCAN : ST_FINISH;
                    end
                end
            end
            ST_SCAN:
            begin
                if (!issue_done)
                begin
                    cmd.rd_en = 1'b1;
                    cnt_next  = cnt_reg + CNT_W'(1);
                end
                else if (!stat.busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (!out_vld_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (cmd.out_load)
        begin
            out_vld_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

endmodule

// ===== hdl/npcs_datapath.sv =====
// Datapath: palette memory, distance pipeline, best-match tracking and result register.
module npcs_datapath
    import npcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [1:0]           cfg_wdata,
    input  logic [IDX_W-1:0]     entry_index,
    input  logic [COMP_IN_W-1:0] red,
    input  logic [COMP_IN_W-1:0] green,
    input  logic [COMP_IN_W-1:0] blue,
    input  npcs_cmd_t            cmd,
    output npcs_stat_t           stat,
    output logic [VALUE_W-1:0]   colour_value,
    output logic                 colour_found
);

    logic [ENTRY_W-1:0] palette_mem [PAL_ENTRIES];

    mode_t              mode_reg;
    logic [COMP_W-1:0]  r_reg, g_reg, b_reg;
    logic [COMP_W-1:0]  r_sat, g_sat, b_sat;
    logic               idx_ok;

    logic               s1_vld_reg, s2_vld_reg;
    logic [ADDR_W-1:0]  s1_idx_reg, s2_idx_reg;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [SQ_W-1:0]    sq_r_reg, sq_g_reg, sq_b_reg;
    logic [DIST_W-1:0]  dist_sum;
    logic [DIST_W-1:0]  best_reg;
    logic [ADDR_W-1:0]  found_reg;
    logic               stop_reg;
    logic               better;

    logic [VALUE_W-1:0] value_next;
    logic               found_next;
    logic [VALUE_W-1:0] value_reg;
    logic               found_flag_reg;

    assign r_sat  = sat8(red);
    assign g_sat  = sat8(green);
    assign b_sat  = sat8(blue);
    assign idx_ok = ({1'b0, entry_index} < (IDX_W + 1)'(PAL_ENTRIES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_INDEXED;
        end
        else if (cfg_we)
        begin
            mode_reg <= mode_t'(cfg_wdata);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en && idx_ok)
        begin
            palette_mem[entry_index[ADDR_W-1:0]] <= {r_sat, g_sat, b_sat};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= palette_mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            r_reg <= r_sat;
            g_reg <= g_sat;
            b_reg <= b_sat;
        end
        s1_idx_reg <= cmd.rd_addr;
        s2_idx_reg <= s1_idx_reg;
        sq_r_reg   <= sq_diff(rd_data_reg[3*COMP_W-1:2*COMP_W], r_reg);
        sq_g_reg   <= sq_diff(rd_data_reg[2*COMP_W-1:COMP_W], g_reg);
        sq_b_reg   <= sq_diff(rd_data_reg[COMP_W-1:0], b_reg);
    end

    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign better   = s2_vld_reg && !stop_reg && (dist_sum < best_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            stop_reg   <= 1'b0;
            best_reg   <= DIST_MAX;
            found_reg  <= '0;
        end
        else
        begin
            s1_vld_reg <= cmd.rd_en;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.capture)
            begin
                stop_reg  <= 1'b0;
                best_reg  <= DIST_MAX;
                found_reg <= '0;
            end
            else if (better)
            begin
                best_reg  <= dist_sum;
                found_reg <= s2_idx_reg;
                if (dist_sum < NEAR_LIMIT)
                begin
                    stop_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        value_next = '0;
        found_next = 1'b1;
        unique case (mode_reg)
            MODE_INDEXED: value_next = VALUE_W'(found_reg);
            MODE_RGB565:  value_next = VALUE_W'({r_reg[7:3], g_reg[7:2], b_reg[7:3]});
            MODE_RGB888:  value_next = {r_reg, g_reg, b_reg};
            default:
            begin
                value_next = '0;
                found_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            value_reg      <= value_next;
            found_flag_reg <= found_next;
        end
    end

    assign colour_value = value_reg;
    assign colour_found = found_flag_reg;

    assign stat.mode = mode_reg;
    assign stat.busy = s1_vld_reg || s2_vld_reg;
    assign stat.stop = stop_reg;

endmodule

// ===== hdl/nearest_palette_colour_search.sv =====
// Top level of the nearest palette colour search: controller plus datapath.
// A palette write gives no result; the next request is taken right after.
// RGB565, RGB888 and unsupported-depth queries pass from the idle to the finish state, which
// loads the result once the output register is free. An indexed query scans entries through
// a three-stage read/square/compare pipeline on one memory read port up to the last entry or
// a match below NEAR_LIMIT. No request is taken until a query's result has been loaded.
// Reset clears control state and sets indexed mode; palette contents are undefined until written.
module nearest_palette_colour_search
    import npcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    npcs_req_if.sink    req,
    npcs_rsp_if.source  rsp,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_wdata
);

    npcs_cmd_t  cmd;
    npcs_stat_t stat;

    npcs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (req.valid),
        .in_req_type (req.req_type),
        .in_ready    (req.ready),
        .out_valid   (rsp.valid),
        .out_ready   (rsp.ready),
        .stat        (stat),
        .cmd         (cmd)
    );

    npcs_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .entry_index  (req.entry_index),
        .red          (req.red),
        .green        (req.green),
        .blue         (req.blue),
        .cmd          (cmd),
        .stat         (stat),
        .colour_value (rsp.colour_value),
        .colour_found (rsp.colour_found)
    );

endmodule

// ===== tb/nearest_palette_colour_search_tb.sv =====
// Self-checking testbench for the nearest palette colour search block.
`timescale 1ns / 100ps

module nearest_palette_colour_search_tb
    import npcs_pkg::*;
();

    localparam int unsigned CLOSE_ENOUGH  = 8;
    localparam int unsigned BATCH_ITEMS   = 92;
    localparam int unsigned DRAIN_LIMIT   = 500000;
    localparam int unsigned SETTLE_CYCLES = 8;

    typedef struct {
        req_t                 kind;
        logic [IDX_W-1:0]     index;
        logic [COMP_IN_W-1:0] red;
        logic [COMP_IN_W-1:0] green;
        logic [COMP_IN_W-1:0] blue;
    } colour_request_t;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               found;
    } colour_answer_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;

    npcs_req_if req_ch ();
    npcs_rsp_if rsp_ch ();

    nearest_palette_colour_search uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    colour_request_t    colour_requests[$];
    colour_answer_t     expected_answers[$];
    colour_request_t    on_bus;
    logic [ENTRY_W-1:0] shadow_palette [PAL_ENTRIES];
    mode_t              shadow_depth;
    int unsigned        sender_idle_pct;
    int unsigned        receiver_stall_pct;
    int unsigned        failures;

    always #5 clk = ~clk;

    function automatic logic [COMP_W-1:0] clamp_channel(input logic [COMP_IN_W-1:0] v);
        return (v > COMP_IN_W'(255)) ? {COMP_W{1'b1}} : v[COMP_W-1:0];
    endfunction

    function automatic int unsigned channel_gap_sq(input logic [COMP_W-1:0] a,
                                                   input logic [COMP_W-1:0] b);
        int d;
        d = int'(a) - int'(b);
        return d * d;
    endfunction

    function automatic void predict_answer(input colour_request_t it);
        logic [COMP_W-1:0] r;
        logic [COMP_W-1:0] g;
        logic [COMP_W-1:0] b;
        logic [ENTRY_W-1:0] e;
        int unsigned best;
        int unsigned gap_sum;
        int unsigned hit;
        int i;
        colour_answer_t ans;
        r = clamp_channel(it.red);
        g = clamp_channel(it.green);
        b = clamp_channel(it.blue);
        if (it.kind == REQ_WRITE)
        begin
            shadow_palette[it.index] = {r, g, b};
            return;
        end
        ans.found = 1'b1;
        case (shadow_depth)
            MODE_INDEXED:
            begin
                best = 32'hFFFF_FFFF;
                hit = 0;
                for (i = 0; i < PAL_ENTRIES; i++)
                begin
                    e = shadow_palette[i];
                    gap_sum = channel_gap_sq(e[23:16], r) + channel_gap_sq(e[15:8], g)
                            + channel_gap_sq(e[7:0], b);
                    if (gap_sum < best)
                    begin
                        best = gap_sum;
                        hit = i;
                        if (best < CLOSE_ENOUGH)
                            break;
                    end
                end
                ans.value = VALUE_W'(hit);
            end
            MODE_RGB565: ans.value = {8'd0, r[7:3], g[7:2], b[7:3]};
            MODE_RGB888: ans.value = {r, g, b};
            default:
            begin
                ans.value = '0;
                ans.found = 1'b0;
            end
        endcase
        expected_answers.push_back(ans);
    endfunction

    // Request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predict_answer(on_bus);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (colour_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    on_bus = colour_requests.pop_front();
                    req_ch.valid       <= 1'b1;
                    req_ch.req_type    <= on_bus.kind;
                    req_ch.entry_index <= on_bus.index;
                    req_ch.red         <= on_bus.red;
                    req_ch.green       <= on_bus.green;
                    req_ch.blue        <= on_bus.blue;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Answer monitor
    always @(posedge clk or negedge rst_n)
    begin
        colour_answer_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_answers.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("unexpected answer: value %h found %b",
                                 rsp_ch.colour_value, rsp_ch.colour_found);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (rsp_ch.colour_value !== want.value
                        || rsp_ch.colour_found !== want.found)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display("mismatch: expected value %h found %b, got value %h found %b",
                                     want.value, want.found,
                                     rsp_ch.colour_value, rsp_ch.colour_found);
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    function automatic void push_request(input req_t k, input logic [IDX_W-1:0] idx,
                                         input logic [COMP_IN_W-1:0] r,
                                         input logic [COMP_IN_W-1:0] g,
                                         input logic [COMP_IN_W-1:0] b);
        colour_request_t it;
        it.kind  = k;
        it.index = idx;
        it.red   = r;
        it.green = g;
        it.blue  = b;
        colour_requests.push_back(it);
    endfunction

    function automatic logic [COMP_IN_W-1:0] pick_component();
        case ($urandom_range(9))
            0: return '0;
            1: return COMP_IN_W'(255);
            2: return COMP_IN_W'($urandom_range(1023, 256));
            3: return '1;
            default: return COMP_IN_W'($urandom_range(255));
        endcase
    endfunction

    function automatic logic [COMP_IN_W-1:0] near_component(input logic [COMP_W-1:0] base);
        int v;
        v = int'(base) + int'($urandom_range(4)) - 2;
        if (v < 0)
            v = 0;
        if (v > 255)
            v = 255;
        return COMP_IN_W'(v);
    endfunction

    function automatic void push_random_item();
        logic [ENTRY_W-1:0] seen;
        logic [IDX_W-1:0]   idx;
        int unsigned        roll;
        roll = $urandom_range(99);
        idx  = IDX_W'($urandom_range(255));
        seen = shadow_palette[$urandom_range(PAL_ENTRIES - 1)];
        if (roll < 30)
            push_request(REQ_WRITE, idx, pick_component(), pick_component(), pick_component());
        else if (roll < 38)
            push_request(REQ_WRITE, idx, COMP_IN_W'(seen[23:16]), COMP_IN_W'(seen[15:8]),
                         COMP_IN_W'(seen[7:0]));
        else if (roll < 68)
            push_request(REQ_FIND, idx, near_component(seen[23:16]),
                         near_component(seen[15:8]), near_component(seen[7:0]));
        else
            push_request(REQ_FIND, idx, pick_component(), pick_component(), pick_component());
    endfunction

    task automatic settle_block();
        int unsigned waited;
        waited = 0;
        while ((colour_requests.size() != 0 || req_ch.valid || expected_answers.size() != 0)
               && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_answers.size() != 0)
        begin
            failures++;
            $display("%0d expected answers never arrived", expected_answers.size());
            expected_answers.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_depth(input mode_t m);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_depth = m;
    endtask

    task automatic run_batch();
        int unsigned n;
        for (n = 0; n < BATCH_ITEMS / 2; n++)
            push_random_item();
        settle_block();
        for (n = BATCH_ITEMS / 2; n < BATCH_ITEMS; n++)
            push_random_item();
        settle_block();
    endtask

    initial
    begin
        mode_t depth_plan [4];
        int unsigned stall_plan [4][2];
        int p;
        int j;
        int i;
        depth_plan = '{MODE_INDEXED, MODE_RGB565, MODE_RGB888, MODE_NONE};
        stall_plan = '{'{0, 0}, '{88, 0}, '{0, 88}, '{20, 20}};
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_WRITE;
        req_ch.entry_index = '0;
        req_ch.red         = '0;
        req_ch.green       = '0;
        req_ch.blue        = '0;
        rsp_ch.ready       = 1'b0;
        shadow_depth       = MODE_INDEXED;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        failures           = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // fill the whole palette with a spaced grid before any indexed search
        for (i = 0; i < PAL_ENTRIES; i++)
            push_request(REQ_WRITE, IDX_W'(i), COMP_IN_W'((i >> 5) * 36),
                         COMP_IN_W'(((i >> 2) & 7) * 36), COMP_IN_W'((i & 3) * 85));
        settle_block();

        set_depth(MODE_INDEXED);
        push_request(REQ_FIND, '0, '0, '0, '0);
        push_request(REQ_FIND, '1, '1, '1, '1);
        push_request(REQ_FIND, 8'h5A, 10'd18, '0, '0);
        push_request(REQ_FIND, 8'hA5, 10'd36, 10'd36, 10'd86);
        push_request(REQ_FIND, '0, 10'd256, 10'd512, 10'd300);
        push_request(REQ_WRITE, 8'd255, '1, 10'd256, 10'd255);
        push_request(REQ_FIND, '1, 10'd1000, 10'd1000, 10'd1000);
        push_request(REQ_WRITE, 8'd3, '0, '0, '0);
        push_request(REQ_FIND, '0, '0, '0, 10'd2);
        push_request(REQ_FIND, '0, '0, '0, 10'd3);
        settle_block();

        set_depth(MODE_RGB565);
        push_request(REQ_FIND, '0, 10'd255, 10'd255, 10'd255);
        push_request(REQ_FIND, '1, '0, '0, '0);
        push_request(REQ_FIND, 8'h33, '1, '0, 10'd512);
        push_request(REQ_FIND, 8'hCC, 10'h0F, 10'hF0, 10'hAA);
        settle_block();

        set_depth(MODE_RGB888);
        push_request(REQ_FIND, '0, '1, 10'd7, 10'd256);
        push_request(REQ_FIND, '1, 10'h0F, 10'hF0, 10'hAA);
        push_request(REQ_WRITE, 8'd3, '0, '0, '0);
        settle_block();

        set_depth(MODE_NONE);
        push_request(REQ_FIND, '0, '0, '0, '0);
        push_request(REQ_WRITE, 8'd128, 10'd64, 10'd64, 10'd64);
        push_request(REQ_FIND, '1, '1, '1, '1);
        settle_block();

        for (p = 0; p < 4; p++)
        begin
            sender_idle_pct    = stall_plan[p][0];
            receiver_stall_pct = stall_plan[p][1];
            for (j = 0; j < 4; j++)
            begin
                set_depth(depth_plan[(j + p) % 4]);
                run_batch();
            end
        end

        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        settle_block();
        if (failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("TB_ERROR");
        $finish;
    end

endmodule
